### rtl/core/pfah_pkg.sv
// pfah_pkg: shared constants and types for the polygon fan area core.
// No dependencies; every other file in rtl/core imports it.
package pfah_pkg;
	localparam int unsigned PFAH_COORD_BITS   = 20;
	localparam int unsigned PFAH_MAX_VERTICES = 4096;
	localparam int unsigned AREA_W            = 64;
	// edge radicand scale: 2^16 gives 8 fractional bits on the length
	localparam int unsigned FRAC_SHIFT        = 16;
	// Heron: area = sqrt(product) / 4
	localparam int unsigned AREA_DIV_SHIFT    = 2;
	localparam int unsigned MIN_TRI_VERTS     = 3;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;
endpackage

### rtl/core/pfah_vtx_if.sv
// pfah_vtx_if, pfah_res_if: valid/ready channels for vertex and result words.
// Depends on pfah_pkg.
interface pfah_vtx_if import pfah_pkg::*; #(
	parameter int unsigned CB = PFAH_COORD_BITS
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CB-1:0] vert_x;
	logic signed [CB-1:0] vert_y;
	logic signed [CB-1:0] vert_z;
	logic                 last_vertex;

	modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

interface pfah_res_if import pfah_pkg::*; #(
	parameter int unsigned TW = $clog2(PFAH_MAX_VERTICES + 1)
) ();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] area_sum;
	logic [TW-1:0]     vertex_total;
	logic              overflowed;

	modport source (output valid, area_sum, vertex_total, overflowed, input ready);
	modport sink (input valid, area_sum, vertex_total, overflowed, output ready);
endinterface

### rtl/core/polygon_fan_area_heron_3d_core.sv
// polygon_fan_area_heron_3d_core: polygon area by fan triangulation and Heron.
// Depends on pfah_pkg, pfah_vtx_if/pfah_res_if, pfah_mul and pfah_sqrt.
//
//   channel | dir | word                                   | accepted when
//   vtx     | in  | vert_x, vert_y, vert_z, last_vertex    | vtx.valid & vtx.ready
//   res     | out | area_sum, vertex_total, overflowed     | res.valid & res.ready
//
// The first two vertices of a polygon are only stored. Each later
// vertex runs its triangle through one serial multiplier and one serial root:
// each edge from its squared axis differences and a root, then the product
// of the Heron factors and a final root.
// Reset clears the polygon state and the result register; no clearing pass.
// A result waits in its output register; vtx.ready stays low while a closing
// vertex waits for that register to drain.
module polygon_fan_area_heron_3d_core import pfah_pkg::*; #(
	parameter int unsigned COORD_BITS   = PFAH_COORD_BITS,
	parameter int unsigned MAX_VERTICES = PFAH_MAX_VERTICES
) (
	input  logic      clk,
	input  logic      arst_n,
	pfah_vtx_if.sink  vtx,
	pfah_res_if.source res
);
	localparam int unsigned C    = COORD_BITS;
	localparam int unsigned TW   = $clog2(MAX_VERTICES + 1);
	localparam int unsigned DW   = C + 1;                       // |difference|
	localparam int unsigned D2W  = 2 * DW + 2;                  // squared distance
	localparam int unsigned N2H  = (D2W + FRAC_SHIFT + 1) / 2;  // edge root bits
	localparam int unsigned EW   = N2H;
	localparam int unsigned FW   = EW + 2;                      // Heron factor
	localparam int unsigned PW   = 4 * FW;                      // factor product
	localparam int unsigned RW   = PW / 2;
	localparam int unsigned MCW  = $clog2(FW + 1);
	localparam int unsigned SCW  = $clog2(RW + 1);
	localparam int unsigned XW   = (RW > AREA_W + AREA_DIV_SHIFT) ? RW
		: AREA_W + AREA_DIV_SHIFT + 1;
	localparam int unsigned ALIGN = FRAC_SHIFT + PW - 2 * N2H;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_MULW, ST_SQ, ST_SQW,
		ST_FAC, ST_FACW, ST_RT, ST_RTW, ST_ADD, ST_FIN
	} state_t;

	state_t              state_q;
	logic [3*C-1:0]      first_q;
	logic [3*C-1:0]      prior_q;
	logic [3*C-1:0]      cur_q;
	logic                last_q;
	logic [TW-1:0]       cnt_q;
	logic [AREA_W-1:0]   accum_q;
	logic                sat_q;
	logic [1:0]          edge_sel_q;
	logic [1:0]          axis_q;
	logic [1:0]          fac_q;
	logic [3*EW-1:0]     edges_q;
	logic [AREA_W-1:0]   tri_q;
	logic                tri_ovf_q;
	logic                res_valid_q;
	logic [AREA_W-1:0]   res_area_q;
	logic [TW-1:0]       res_total_q;
	logic                res_ovf_q;

	// endpoints of the current edge: (first,prior), (prior,cur), (cur,first)
	logic [3*C-1:0]      pa_pt;
	logic [3*C-1:0]      pb_pt;
	logic signed [C-1:0] pa;
	logic signed [C-1:0] pb;
	logic signed [C:0]   diff;
	logic [DW-1:0]       absd;

	always_comb begin
		case (edge_sel_q)
			2'd0: begin
				pa_pt = first_q;
				pb_pt = prior_q;
			end
			2'd1: begin
				pa_pt = prior_q;
				pb_pt = cur_q;
			end
			default: begin
				pa_pt = cur_q;
				pb_pt = first_q;
			end
		endcase
	end

	assign pa   = pa_pt[axis_q*C +: C];
	assign pb   = pb_pt[axis_q*C +: C];
	assign diff = (C+1)'(pa) - (C+1)'(pb);
	assign absd = diff[C] ? DW'(-diff) : DW'(diff);

	// Heron factors; the three difference factors are clamped at zero
	logic [EW-1:0] ea;
	logic [EW-1:0] eb;
	logic [EW-1:0] ec;
	logic [FW-1:0] f0;
	logic [FW-1:0] f1;
	logic [FW-1:0] f2;
	logic [FW-1:0] f3;
	logic [FW-1:0] fsel;

	assign ea = edges_q[0 +: EW];
	assign eb = edges_q[EW +: EW];
	assign ec = edges_q[2*EW +: EW];
	assign f0 = FW'(ea) + FW'(eb) + FW'(ec);
	assign f1 = (FW'(ea) + FW'(eb) > FW'(ec)) ? FW'(ea) + FW'(eb) - FW'(ec) : '0;
	assign f2 = (FW'(ea) + FW'(ec) > FW'(eb)) ? FW'(ea) + FW'(ec) - FW'(eb) : '0;
	assign f3 = (FW'(eb) + FW'(ec) > FW'(ea)) ? FW'(eb) + FW'(ec) - FW'(ea) : '0;

	always_comb begin
		case (fac_q)
			2'd1:    fsel = f1;
			2'd2:    fsel = f2;
			default: fsel = f3;
		endcase
	end

	// shared serial units
	logic          mul_start;
	logic [PW-1:0] mul_mcand;
	logic [FW-1:0] mul_mult;
	logic [MCW-1:0] mul_steps;
	logic          mul_accum;
	logic [PW-1:0] mul_prod;
	unit_stat_t    mul_stat;
	logic          sq_start;
	logic [PW-1:0] sq_rad;
	logic [SCW-1:0] sq_steps;
	logic [RW-1:0] sq_root;
	unit_stat_t    sq_stat;

	assign mul_start = (state_q == ST_DIFF) || (state_q == ST_FAC);
	assign sq_start  = (state_q == ST_SQ) || (state_q == ST_RT);

	always_comb begin
		if (state_q == ST_DIFF) begin
			mul_mcand = PW'(absd);
			mul_mult  = FW'(absd);
			mul_steps = MCW'(DW);
			mul_accum = (axis_q != 2'd0);
		end else begin
			mul_mcand = (fac_q == 2'd1) ? PW'(f0) : mul_prod;
			mul_mult  = fsel;
			mul_steps = MCW'(FW);
			mul_accum = 1'b0;
		end
	end

	always_comb begin
		if (state_q == ST_SQ) begin
			sq_rad   = mul_prod << ALIGN;
			sq_steps = SCW'(N2H);
		end else begin
			sq_rad   = mul_prod;
			sq_steps = SCW'(RW);
		end
	end

	pfah_mul #(.PW(PW), .FW(FW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mcand),
		.mult   (mul_mult),
		.steps  (mul_steps),
		.accum  (mul_accum),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	pfah_sqrt #(.PW(PW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.steps  (sq_steps),
		.root   (sq_root),
		.stat   (sq_stat)
	);

	// triangle area = root / 4; anything above 64 bits marks overflow
	logic [XW-1:0]     root_x;
	logic [AREA_W:0]   sum;
	logic [TW-1:0]     cnt_next;
	logic              sat_next;
	logic              accept;

	assign root_x   = XW'(sq_root);
	assign sum      = (AREA_W+1)'(accum_q) + (AREA_W+1)'(tri_q);
	assign cnt_next = (cnt_q < TW'(MAX_VERTICES)) ? cnt_q + 1'b1 : cnt_q;
	assign sat_next = sat_q | (cnt_q >= TW'(MAX_VERTICES));
	assign accept   = vtx.valid && vtx.ready;

	assign vtx.ready        = (state_q == ST_IDLE);
	assign res.valid        = res_valid_q;
	assign res.area_sum     = res_area_q;
	assign res.vertex_total = res_total_q;
	assign res.overflowed   = res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= '0;
			prior_q     <= '0;
			cur_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			accum_q     <= '0;
			sat_q       <= 1'b0;
			edge_sel_q  <= '0;
			axis_q      <= '0;
			fac_q       <= '0;
			edges_q     <= '0;
			tri_q       <= '0;
			tri_ovf_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_area_q  <= '0;
			res_total_q <= '0;
			res_ovf_q   <= 1'b0;
		end else begin
			// drop the result word once taken, unless a closing vertex reloads it
			if (res.valid && res.ready && !(state_q == ST_FIN && last_q)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_q      <= {vtx.vert_z, vtx.vert_y, vtx.vert_x};
						last_q     <= vtx.last_vertex;
						edge_sel_q <= '0;
						axis_q     <= '0;
						fac_q      <= 2'd1;
						state_q    <= (cnt_q >= TW'(2)) ? ST_DIFF : ST_FIN;
					end
				end
				ST_DIFF: state_q <= ST_MULW;
				ST_MULW: begin
					if (mul_stat.done) begin
						if (axis_q == 2'd2) begin
							state_q <= ST_SQ;
						end else begin
							axis_q  <= axis_q + 1'b1;
							state_q <= ST_DIFF;
						end
					end
				end
				ST_SQ: state_q <= ST_SQW;
				ST_SQW: begin
					if (sq_stat.done) begin
						edges_q[edge_sel_q*EW +: EW] <= sq_root[EW-1:0];
						axis_q <= '0;
						if (edge_sel_q == 2'd2) begin
							state_q <= ST_FAC;
						end else begin
							edge_sel_q <= edge_sel_q + 1'b1;
							state_q    <= ST_DIFF;
						end
					end
				end
				ST_FAC: state_q <= ST_FACW;
				ST_FACW: begin
					if (mul_stat.done) begin
						if (fac_q == 2'd3) begin
							state_q <= ST_RT;
						end else begin
							fac_q   <= fac_q + 1'b1;
							state_q <= ST_FAC;
						end
					end
				end
				ST_RT: state_q <= ST_RTW;
				ST_RTW: begin
					if (sq_stat.done) begin
						tri_q     <= root_x[AREA_W+AREA_DIV_SHIFT-1:AREA_DIV_SHIFT];
						tri_ovf_q <= |root_x[XW-1:AREA_W+AREA_DIV_SHIFT];
						state_q   <= ST_ADD;
					end
				end
				ST_ADD: begin
					// saturate the area sum
					if (tri_ovf_q || sum[AREA_W]) begin
						accum_q <= '1;
						sat_q   <= 1'b1;
					end else begin
						accum_q <= sum[AREA_W-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						if (cnt_q == '0) begin
							first_q <= cur_q;
						end
						prior_q <= cur_q;
						cnt_q   <= cnt_next;
						sat_q   <= sat_next;
						state_q <= ST_IDLE;
					end else if (!res_valid_q || res.ready) begin
						// close the polygon, load the result word and clear the polygon state
						res_valid_q <= 1'b1;
						res_area_q  <= (cnt_next < TW'(MIN_TRI_VERTS)) ? '0 : accum_q;
						res_total_q <= cnt_next;
						res_ovf_q   <= sat_next;
						first_q     <= '0;
						prior_q     <= '0;
						cnt_q       <= '0;
						accum_q     <= '0;
						sat_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_small_poly_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.vertex_total < TW'(MIN_TRI_VERTS))) |-> (res.area_sum == '0))
		else $error("polygon under three vertices reports nonzero area");
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && sq_stat.busy))
		else $error("multiplier and root unit busy together");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= TW'(MAX_VERTICES))
		else $error("vertex count above limit");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !vtx.ready)
		else $error("second vertex taken before the first finished");
`endif
endmodule

### rtl/core/pfah_mul.sv
// pfah_mul: serial shift-add multiplier, one multiplier bit per cycle.
// Depends on pfah_pkg.
module pfah_mul import pfah_pkg::*; #(
	parameter int unsigned PW = 128,
	parameter int unsigned FW = 32,
	localparam int unsigned CW = $clog2(FW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] mcand,
	input  logic [FW-1:0] mult,
	input  logic [CW-1:0] steps,
	input  logic          accum,
	output logic [PW-1:0] prod,
	output unit_stat_t    stat
);
	logic [PW-1:0] mc_q;
	logic [FW-1:0] ml_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add the shifted multiplicand where the multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			ml_q <= mult;
			if (!accum) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (ml_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q << 1;
			ml_q <= ml_q >> 1;
		end
	end

	assign prod = acc_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

### rtl/core/pfah_sqrt.sv
// pfah_sqrt: digit-recurrence floor square root, one root bit per cycle.
// Depends on pfah_pkg. The radicand is consumed two bits a cycle from its top.
module pfah_sqrt import pfah_pkg::*; #(
	parameter int unsigned PW = 128,
	localparam int unsigned HW = PW / 2,
	localparam int unsigned CW = $clog2(HW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] rad,
	input  logic [CW-1:0] steps,
	output logic [HW-1:0] root,
	output unit_stat_t    stat
);
	logic [PW-1:0] rad_q;
	logic [HW+1:0] rem_q;
	logic [HW-1:0] root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [HW+3:0] rem_sh;
	logic [HW+3:0] trial;
	logic          fits;

	assign rem_sh = {rem_q, rad_q[PW-1:PW-2]};
	assign trial  = (HW+4)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= (HW+2)'(rem_sh - trial);
				root_q <= {root_q[HW-2:0], 1'b1};
			end else begin
				rem_q  <= (HW+2)'(rem_sh);
				root_q <= {root_q[HW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule

### tb/tb.sv
// tb: self-checking bench for polygon_fan_area_heron_3d_core.
// Depends on pfah_pkg, pfah_vtx_if/pfah_res_if and the core; predicts each
// closed polygon's area word with its own fixed-point fan/Heron model.
module tb;
	import pfah_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = PFAH_COORD_BITS;
	localparam int TW = $clog2(PFAH_MAX_VERTICES + 1);
	localparam int STALL_LIMIT = 5000;  // covers one triangle plus idling

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		coord_t x, y, z;
	} point_t;

	// one expected result word
	typedef struct {
		logic [AREA_W-1:0] area;
		logic [TW-1:0]     total;
		logic              ovf;
	} area_word_t;

	// one row of the directed table
	typedef struct {
		coord_t            x, y, z;
		bit                last;
		bit                typed;  // expected word typed in below
		logic [AREA_W-1:0] area;
		logic [TW-1:0]     total;
		logic              ovf;
	} vtx_row_t;

	logic clk;
	logic arst_n;

	pfah_vtx_if vtx_ch ();
	pfah_res_if res_ch ();

	polygon_fan_area_heron_3d_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx_ch),
		.res    (res_ch)
	);

	// predictor state: mirrors the polygon registers of the core
	point_t            fan_first;
	point_t            fan_prior;
	int unsigned       fan_count;
	logic [AREA_W-1:0] fan_area;
	logic              fan_sat;

	area_word_t  area_expq[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on;
	bit          sink_idle_on;

	// clock, period 2 ns
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// floor square root of a 128-bit radicand
	function automatic logic [63:0] isqrt128(input logic [127:0] n);
		logic [63:0] r;
		logic [63:0] cand;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= n)
				r = cand;
		end
		return r;
	endfunction

	// edge length with 8 fractional bits: floor(sqrt(d2 * 2^16))
	function automatic logic [63:0] edge_len8(input point_t p, input point_t q);
		longint dx, dy, dz;
		logic [127:0] d2;
		dx = longint'(p.x) - longint'(q.x);
		dy = longint'(p.y) - longint'(q.y);
		dz = longint'(p.z) - longint'(q.z);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dz < 0) dz = -dz;
		d2 = 128'(dx * dx + dy * dy + dz * dz);
		return isqrt128(d2 << FRAC_SHIFT);
	endfunction

	// Heron area of one fan triangle, 16 fractional bits; the root of a
	// product of four sub-32-bit factors always fits, so no overflow here
	function automatic logic [63:0] heron_area(input point_t p0, input point_t p1,
			input point_t p2);
		logic [63:0] a, b, c;
		logic [63:0] f0, f1, f2, f3;
		logic [127:0] prod;
		a = edge_len8(p0, p1);
		b = edge_len8(p1, p2);
		c = edge_len8(p2, p0);
		f0 = a + b + c;
		f1 = (a + b > c) ? a + b - c : 64'd0;
		f2 = (a + c > b) ? a + c - b : 64'd0;
		f3 = (b + c > a) ? b + c - a : 64'd0;
		prod = 128'(f0) * 128'(f1);
		prod = prod * 128'(f2);
		prod = prod * 128'(f3);
		return isqrt128(prod) >> AREA_DIV_SHIFT;
	endfunction

	task automatic fan_clear();
		fan_first = '{0, 0, 0};
		fan_prior = '{0, 0, 0};
		fan_count = 0;
		fan_area  = '0;
		fan_sat   = 1'b0;
	endtask

	// advance the predictor by one accepted vertex; queue a word on the last one
	task automatic fan_advance(input vtx_row_t r);
		point_t v;
		logic [63:0] t;
		logic [63:0] s;
		area_word_t w;
		v = '{r.x, r.y, r.z};
		if (fan_count == 0) begin
			fan_first = v;
		end else if (fan_count >= 2) begin
			t = heron_area(fan_first, fan_prior, v);
			s = fan_area + t;
			if (s < fan_area) begin
				fan_area = '1;
				fan_sat  = 1'b1;
			end else begin
				fan_area = s;
			end
		end
		fan_prior = v;
		if (fan_count < PFAH_MAX_VERTICES)
			fan_count++;
		else
			fan_sat = 1'b1;
		if (r.last) begin
			w.area  = (fan_count < MIN_TRI_VERTS) ? '0 : fan_area;
			w.total = TW'(fan_count);
			w.ovf   = fan_sat;
			if (r.typed) begin
				w.area  = r.area;
				w.total = r.total;
				w.ovf   = r.ovf;
			end
			area_expq.push_back(w);
			fan_clear();
		end
	endtask

	// present one vertex word, hold it until accepted, then predict
	task automatic send_vertex(input vtx_row_t r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			vtx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		vtx_ch.valid       <= 1'b1;
		vtx_ch.vert_x      <= r.x;
		vtx_ch.vert_y      <= r.y;
		vtx_ch.vert_z      <= r.z;
		vtx_ch.last_vertex <= r.last;
		@(posedge clk);
		while (!vtx_ch.ready) @(posedge clk);
		fan_advance(r);
	endtask

	function automatic vtx_row_t plain_row(input coord_t x, input coord_t y,
			input coord_t z, input bit last);
		vtx_row_t r;
		r = '{x, y, z, last, 1'b0, '0, '0, 1'b0};
		return r;
	endfunction

	// random coordinate: small, moderate, extreme or full-width, by mode
	function automatic coord_t rand_coord(input int mode);
		case (mode)
			0: return coord_t'($urandom());
			1: return coord_t'($urandom_range(0, 32) - 16);
			2: return $urandom_range(0, 1) ? coord_t'({1'b0, {(CB-1){1'b1}}}) :
					coord_t'({1'b1, {(CB-1){1'b0}}});
			default: return coord_t'($urandom_range(0, 4096) - 2048);
		endcase
	endfunction

	localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

	// directed table: typed words only where they are obvious
	vtx_row_t dir_tab[] = '{
		// lone vertex closes at once: no triangle
		'{CMAX, CMAX, CMAX, 1, 1, 64'd0, 13'd1, 1'b0},
		// two vertices: still no triangle
		'{CMIN, CMIN, CMIN, 0, 0, 64'd0, 13'd0, 1'b0},
		'{CMAX, CMAX, CMAX, 1, 1, 64'd0, 13'd2, 1'b0},
		// three identical points: zero area
		'{20'sd5, -20'sd7, 20'sd9, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd5, -20'sd7, 20'sd9, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd5, -20'sd7, 20'sd9, 1, 1, 64'd0, 13'd3, 1'b0},
		// extreme corner triangle
		'{CMIN, CMIN, CMIN, 0, 0, 64'd0, 13'd0, 1'b0},
		'{CMAX, CMIN, CMAX, 0, 0, 64'd0, 13'd0, 1'b0},
		'{CMIN, CMAX, CMAX, 1, 0, 64'd0, 13'd0, 1'b0},
		// small square, two fan triangles
		'{20'sd0, 20'sd0, 20'sd0, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd4, 20'sd0, 20'sd0, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd4, 20'sd4, 20'sd0, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd0, 20'sd4, 20'sd0, 1, 0, 64'd0, 13'd0, 1'b0},
		// collinear points: factors clamp at zero
		'{-20'sd3, -20'sd3, -20'sd3, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd1, 20'sd1, 20'sd1, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd6, 20'sd6, 20'sd6, 1, 0, 64'd0, 13'd0, 1'b0},
		// skewed 3D triangle with mixed signs
		'{-20'sd1000, 20'sd250, 20'sd77, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd31, -20'sd999, 20'sd4000, 0, 0, 64'd0, 13'd0, 1'b0},
		'{20'sd12345, 20'sd2, -20'sd60000, 1, 0, 64'd0, 13'd0, 1'b0}
	};

	// result sink: ready idles in bursts
	initial begin
		int unsigned hold;
		hold = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				hold = $urandom_range(1, 8) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// compare each accepted result word against the oldest expectation
	always @(posedge clk) begin
		area_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (area_expq.size() == 0) begin
				$display("%0t: unexpected result word area=%h total=%0d ovf=%b",
					$realtime, res_ch.area_sum, res_ch.vertex_total, res_ch.overflowed);
				mismatches++;
			end else begin
				w = area_expq.pop_front();
				if (res_ch.area_sum !== w.area) begin
					$display("%0t: area_sum expected %h actual %h",
						$realtime, w.area, res_ch.area_sum);
					mismatches++;
				end
				if (res_ch.vertex_total !== w.total) begin
					$display("%0t: vertex_total expected %0d actual %0d",
						$realtime, w.total, res_ch.vertex_total);
					mismatches++;
				end
				if (res_ch.overflowed !== w.ovf) begin
					$display("%0t: overflowed expected %b actual %b",
						$realtime, w.ovf, res_ch.overflowed);
					mismatches++;
				end
			end
		end
	end

	// watchdog: count cycles in which no word moves on either channel
	always @(posedge clk) begin
		if ((vtx_ch.valid && vtx_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// main sequence
	initial begin
		int unsigned sent;
		int unsigned plen;
		int mode;
		bit last;
		vtx_row_t r;
		vtx_ch.valid       = 1'b0;
		vtx_ch.vert_x      = '0;
		vtx_ch.vert_y      = '0;
		vtx_ch.vert_z      = '0;
		vtx_ch.last_vertex = 1'b0;
		arst_n       = 1'b0;
		idle_on      = 1'b1;
		sink_idle_on = 1'b1;
		fan_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) send_vertex(dir_tab[i]);

		// one long polygon at extreme corners: about 300 large triangles
		// saturate the area sum; hold both sides busy to keep it short
		idle_on      = 1'b0;
		sink_idle_on = 1'b0;
		send_vertex(plain_row(CMIN, CMIN, CMIN, 1'b0));
		for (int k = 1; k < 320; k++) begin
			r = (k % 2) ? plain_row(CMAX, CMAX, CMIN, 1'b0) :
				plain_row(CMAX, CMIN, CMAX, 1'b0);
			r.last = (k == 319);
			send_vertex(r);
		end
		idle_on      = 1'b1;
		sink_idle_on = 1'b1;

		// random polygons; mostly 3..10 vertices, some runts of 1..2
		sent = 0;
		while (sent < 510) begin
			plen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) :
				$urandom_range(3, 10);
			mode = $urandom_range(0, 3);
			if (sent > 410) begin
				idle_on      = 1'b0;
				sink_idle_on = 1'b0;
			end
			for (int k = 0; k < plen; k++) begin
				last = (k == plen - 1);
				if ($urandom_range(0, 4) == 0) mode = $urandom_range(0, 3);
				send_vertex(plain_row(rand_coord(mode), rand_coord(mode),
					rand_coord(mode), last));
				sent++;
			end
		end
		vtx_ch.valid <= 1'b0;

		// drain, then let any trailing activity settle
		while (area_expq.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
